// ===== design/prf_pkg.sv =====
// package for the park rotation unit: q16 constants, shared types and the range reduction helper
// no dependencies
package prf_pkg;

  localparam int unsigned QOne        = 65536;
  localparam int unsigned QPi         = 205887;
  localparam int unsigned QTwoPi      = 411775;
  localparam int unsigned QHalfPi     = 102944;
  localparam int unsigned QQuarterPi  = 51472;

  // reciprocal multipliers for exact truncating division of 17-bit operands
  localparam int unsigned RecipDiv6     = 174763;
  localparam int unsigned ShiftDiv6     = 20;
  localparam int unsigned RecipDiv24    = 174763;
  localparam int unsigned ShiftDiv24    = 22;
  localparam int unsigned RecipDiv120   = 139811;
  localparam int unsigned ShiftDiv120   = 24;
  localparam int unsigned RecipDiv720   = 186414;
  localparam int unsigned ShiftDiv720   = 27;
  localparam int unsigned RecipDiv5040  = 213045;
  localparam int unsigned ShiftDiv5040  = 30;

  typedef enum logic {
    CMD_FWD = 1'b0,
    CMD_INV = 1'b1
  } cmd_e;

  // payload carried down the delay line to the rotation stage
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } item_t;

  // state of one trig evaluation in flight
  typedef struct packed {
    logic        neg;
    logic        use_cos;
    logic [16:0] x;
  } trig_t;

  // reduce angle to [0, pi/4], x in (-2pi, 4pi)
  function automatic trig_t reduce(input logic signed [20:0] xin);
    logic signed [20:0] x;
    trig_t r;
    x = xin;
    r.neg = 1'b0;
    if (x < 0) x = x + 21'(QTwoPi);
    if (x >= 21'sd411775) x = x - 21'(QTwoPi);
    if (x >= 21'sd205887) begin
      r.neg = 1'b1;
      x = x - 21'(QPi);
    end
    if (x > 21'sd102944) x = 21'(QPi) - x;
    r.use_cos = (x > 21'sd51472);
    if (r.use_cos) x = 21'(QHalfPi) - x;
    r.x = x[16:0];
    return r;
  endfunction

endpackage

// ===== design/prf_trig.sv =====
// sine or cosine polynomial over six register stages, powers, constant divisions, sum
// depends on prf_pkg
module prf_trig (
  input  logic                clk_i,
  input  logic                en_i,
  input  prf_pkg::trig_t      t_i,
  output logic signed [17:0]  val_o
);

  prf_pkg::trig_t t1_q, t2_q, t3_q, t4_q;
  logic [16:0] x1_q, x2_q, x3_q, x4_q;
  logic [16:0] p2_q, p2b_q, p2c_q;
  logic [16:0] p3_q, p4_q;
  logic [16:0] p5_q, p6_q, p7_q;
  logic [16:0] d2_q, d2b_q, d3_q, d3b_q, d4_q, d4b_q, d5_q, d6_q;
  logic [16:0] q7_q;
  logic [17:0] part_q;
  logic        neg5_q;
  logic [33:0] m2, m3, m4, m5, m6, m7;
  logic [34:0] md3, md4, md5, md6, md7;

  // stage 1: square
  assign m2 = t_i.x * t_i.x;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= t_i;
      x1_q <= t_i.x;
      p2_q <= m2[32:16];
    end
  end

  // stage 2: third and fourth power
  assign m3 = p2_q * x1_q;
  assign m4 = p2_q * p2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q  <= t1_q;
      x2_q  <= x1_q;
      p2b_q <= p2_q;
      p3_q  <= m3[32:16];
      p4_q  <= m4[32:16];
    end
  end

  // stage 3: fifth and sixth power, low order divisions
  assign m5  = p3_q * p2b_q;
  assign m6  = p4_q * p2b_q;
  assign md3 = p3_q * 18'(prf_pkg::RecipDiv6);
  assign md4 = p4_q * 18'(prf_pkg::RecipDiv24);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_q  <= t2_q;
      x3_q  <= x2_q;
      p2c_q <= p2b_q;
      p5_q  <= m5[32:16];
      p6_q  <= m6[32:16];
      d2_q  <= p2b_q >> 1;
      d3_q  <= 17'(md3 >> prf_pkg::ShiftDiv6);
      d4_q  <= 17'(md4 >> prf_pkg::ShiftDiv24);
    end
  end

  // stage 4: seventh power, higher order divisions
  assign m7  = p5_q * p2c_q;
  assign md5 = p5_q * 18'(prf_pkg::RecipDiv120);
  assign md6 = p6_q * 18'(prf_pkg::RecipDiv720);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_q  <= t3_q;
      x4_q  <= x3_q;
      p7_q  <= m7[32:16];
      d2b_q <= d2_q;
      d3b_q <= d3_q;
      d4b_q <= d4_q;
      d5_q  <= 17'(md5 >> prf_pkg::ShiftDiv120);
      d6_q  <= 17'(md6 >> prf_pkg::ShiftDiv720);
    end
  end

  // stage 5: last division and partial series sum
  assign md7 = p7_q * 18'(prf_pkg::RecipDiv5040);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg5_q <= t4_q.neg;
      if (t4_q.use_cos) begin
        q7_q   <= '0;
        part_q <= 18'(prf_pkg::QOne) - 18'(d2b_q) + 18'(d4b_q) - 18'(d6_q);
      end else begin
        q7_q   <= 17'(md7 >> prf_pkg::ShiftDiv5040);
        part_q <= 18'(x4_q) - 18'(d3b_q) + 18'(d5_q);
      end
    end
  end

  // stage 6: final term and sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_o <= neg5_q ? $signed(18'(q7_q) - part_q) : $signed(part_q - 18'(q7_q));
    end
  end

endmodule

// ===== design/prf_rot.sv =====
// rotation stage: four products, then sums, two register stages
// depends on prf_pkg
module prf_rot (
  input  logic               clk_i,
  input  logic               en_i,
  input  prf_pkg::item_t     it_i,
  input  logic signed [17:0] c_i,
  input  logic signed [17:0] s_i,
  output logic [31:0]        first_o,
  output logic [31:0]        second_o
);

  logic signed [49:0] pca, psb, psa, pcb;
  logic [31:0] ca_q, sb_q, sa_q, cb_q;
  logic cmd_q;

  // products, low 32 bits of the floor shift
  assign pca = c_i * it_i.a;
  assign psb = s_i * it_i.b;
  assign psa = s_i * it_i.a;
  assign pcb = c_i * it_i.b;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q  <= pca[47:16];
      sb_q  <= psb[47:16];
      sa_q  <= psa[47:16];
      cb_q  <= pcb[47:16];
      cmd_q <= it_i.cmd;
    end
  end

  // sums; -s*a is formed by negating the full product before the floor shift
  logic [31:0] nsa;
  logic signed [49:0] psa_n;
  logic [31:0] nsa_q;
  assign psa_n = -psa;
  always_ff @(posedge clk_i) begin
    if (en_i) nsa_q <= psa_n[47:16];
  end
  assign nsa = nsa_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (prf_pkg::cmd_e'(cmd_q) == prf_pkg::CMD_FWD) begin
        first_o  <= ca_q + sb_q;
        second_o <= nsa + cb_q;
      end else begin
        first_o  <= ca_q - sb_q;
        second_o <= sa_q + cb_q;
      end
    end
  end

endmodule

// ===== design/park_rotation_fixed_point_unit.sv =====
// park rotation unit: a pipeline from input beat to output beat
// throughput one beat per cycle, the whole pipe advances when the output slot frees
// stages: angle scale, reduce, six polynomial stages, products, sums
// reset clears the valid bits only, payload registers hold anything
// depends on prf_pkg, prf_trig, prf_rot
module park_rotation_fixed_point_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [31:0] first_in_i,
  input  logic [31:0] second_in_i,
  input  logic [15:0] angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] first_out_o,
  output logic [31:0] second_out_o
);

  localparam int Depth = 10;
  logic [Depth-1:0] vld_q;
  logic en;

  // pipe moves when the last slot is empty or taken
  assign en = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stage 1: angle to radians
  prf_pkg::item_t it_q [8];
  logic [34:0] th_m;
  logic [18:0] th_q;
  assign th_m = angle_i * 19'(prf_pkg::QTwoPi);
  always_ff @(posedge clk_i) begin
    if (en) begin
      th_q     <= th_m[34:16];
      it_q[0]  <= '{cmd: cmd_i, a: first_in_i, b: second_in_i};
      for (int i = 1; i < 8; i++) it_q[i] <= it_q[i-1];
    end
  end

  // stage 2: range reduction for sine and cosine
  prf_pkg::trig_t ts_q, tc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_q <= prf_pkg::reduce($signed({2'b0, th_q}));
      tc_q <= prf_pkg::reduce(21'(prf_pkg::QHalfPi) - $signed({2'b0, th_q}));
    end
  end

  logic signed [17:0] s, c;
  prf_trig u_sin (.clk_i, .en_i(en), .t_i(ts_q), .val_o(s));
  prf_trig u_cos (.clk_i, .en_i(en), .t_i(tc_q), .val_o(c));

  prf_rot u_rot (
    .clk_i, .en_i(en), .it_i(it_q[7]), .c_i(c), .s_i(s),
    .first_o(first_out_o), .second_o(second_out_o)
  );

`ifndef SYNTH
  // a beat offered while the output is held and stalled is not taken
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken during stall");
  // an accepted beat sets the entry valid bit of the pipe
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("valid bit lost at entry");
  // a held result stays valid with its first output stable
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(first_out_o)))
    else $error("result changed under stall");
`endif

endmodule
